/* design/bre_pkg.sv */
// Shared constants and helpers for the line rasterizer.
// No dependencies; compiled first.
package bre_pkg;

	// Port widths fixed by the command and pixel formats
	localparam int FIELD_W = 6;
	localparam int COLOUR_W = 8;

	// Default coordinate width
	localparam int COORD_BITS_DEF = 6;

	// Entries in the command queue between front and walker
	localparam int CMDQ_DEPTH = 2;

	// Bits in one classified command: four coordinates, two flags, colour
	function automatic int entry_width(input int coord_bits);
		return 4 * coord_bits + 2 + COLOUR_W;
	endfunction

endpackage

/* design/bre_front.sv */
// Command front end: masks endpoints, finds the major axis and orders the ends.
// Depends on bre_pkg.
module bre_front #(
	parameter int COORD_BITS = bre_pkg::COORD_BITS_DEF
) (
	input  logic [bre_pkg::FIELD_W-1:0]               start_x,
	input  logic [bre_pkg::FIELD_W-1:0]               start_y,
	input  logic [bre_pkg::FIELD_W-1:0]               end_x,
	input  logic [bre_pkg::FIELD_W-1:0]               end_y,
	input  logic [bre_pkg::COLOUR_W-1:0]              colour,
	output logic [bre_pkg::entry_width(COORD_BITS)-1:0] entry
);

	typedef struct packed {
		logic [COORD_BITS-1:0]        major_start;
		logic [COORD_BITS-1:0]        major_end;
		logic [COORD_BITS-1:0]        minor_start;
		logic [COORD_BITS-1:0]        minor_span;
		logic                         minor_up;
		logic                         steep;
		logic [bre_pkg::COLOUR_W-1:0] colour;
	} cmd_t;

	logic [COORD_BITS-1:0] ax, ay, bx, by;
	logic [COORD_BITS-1:0] dx, dy;
	logic [COORD_BITS-1:0] maj_a, maj_b, min_a, min_b;
	logic [COORD_BITS-1:0] min_s, min_e;
	logic                  steep, swap;
	cmd_t                  cmd;

	// Classify: spans, steepness, endpoint order
	always_comb begin
		ax = start_x[COORD_BITS-1:0];
		ay = start_y[COORD_BITS-1:0];
		bx = end_x[COORD_BITS-1:0];
		by = end_y[COORD_BITS-1:0];
		dx = (bx >= ax) ? bx - ax : ax - bx;
		dy = (by >= ay) ? by - ay : ay - by;
		// diagonal lines keep x as the major axis
		steep = dy > dx;
		if (steep) begin
			maj_a = ay;
			min_a = ax;
			maj_b = by;
			min_b = bx;
		end else begin
			maj_a = ax;
			min_a = ay;
			maj_b = bx;
			min_b = by;
		end
		swap = maj_a > maj_b;
		min_s = swap ? min_b : min_a;
		min_e = swap ? min_a : min_b;
		cmd.major_start = swap ? maj_b : maj_a;
		cmd.major_end   = swap ? maj_a : maj_b;
		cmd.minor_start = min_s;
		cmd.minor_span  = steep ? dx : dy;
		cmd.minor_up    = min_e > min_s;
		cmd.steep       = steep;
		cmd.colour      = colour;
	end

	assign entry = cmd;

endmodule

/* design/bre_cmdq.sv */
// Small FIFO holding classified commands between front end and walker.
// Depends on bre_pkg.
module bre_cmdq #(
	parameter int WIDTH = bre_pkg::entry_width(bre_pkg::COORD_BITS_DEF)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int DEPTH = bre_pkg::CMDQ_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/bre_walk.sv */
// Line walker: steps the error term one pixel per cycle into an output register
// while that register is free or popped. Depends on bre_pkg.
module bre_walk #(
	parameter int COORD_BITS = bre_pkg::COORD_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic [bre_pkg::entry_width(COORD_BITS)-1:0] entry,
	input  logic                                       q_empty,
	output logic                                       q_pop,
	output logic                                       empty,
	input  logic                                       pop,
	output logic [bre_pkg::FIELD_W-1:0]                pixel_x,
	output logic [bre_pkg::FIELD_W-1:0]                pixel_y,
	output logic [bre_pkg::COLOUR_W-1:0]               pixel_colour,
	output logic                                       last_pixel
);

	localparam int FW = bre_pkg::FIELD_W;

	typedef struct packed {
		logic [COORD_BITS-1:0]        major_start;
		logic [COORD_BITS-1:0]        major_end;
		logic [COORD_BITS-1:0]        minor_start;
		logic [COORD_BITS-1:0]        minor_span;
		logic                         minor_up;
		logic                         steep;
		logic [bre_pkg::COLOUR_W-1:0] colour;
	} cmd_t;

	cmd_t                  in_cmd, cmd_q;
	logic                  busy_q, out_valid_q;
	logic [COORD_BITS-1:0] major_q, minor_q, err_q, span_q;
	logic [COORD_BITS-1:0] load_span, err_nxt, minor_nxt;
	logic [COORD_BITS:0]   diff, diff_fix;
	logic                  load, emit, at_last;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic [bre_pkg::COLOUR_W-1:0] col_q;
	logic                  last_q;

	assign in_cmd    = cmd_t'(entry);
	assign load      = !busy_q && !q_empty;
	assign q_pop     = load;
	assign emit      = busy_q && (!out_valid_q || pop);
	assign at_last   = (major_q == cmd_q.major_end);
	assign load_span = in_cmd.major_end - in_cmd.major_start;

	// Error step: subtract minor span, add major span back on underflow
	always_comb begin
		diff     = {1'b0, err_q} - {1'b0, cmd_q.minor_span};
		diff_fix = diff + {1'b0, span_q};
		if (diff[COORD_BITS]) begin
			err_nxt   = diff_fix[COORD_BITS-1:0];
			minor_nxt = cmd_q.minor_up ? minor_q + 1'b1 : minor_q - 1'b1;
		end else begin
			err_nxt   = diff[COORD_BITS-1:0];
			minor_nxt = minor_q;
		end
	end

	// Control: walk in progress, output register occupied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && at_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk state and output payload
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q   <= in_cmd;
			major_q <= in_cmd.major_start;
			minor_q <= in_cmd.minor_start;
			span_q  <= load_span;
			err_q   <= load_span >> 1;
		end else if (emit) begin
			major_q <= major_q + 1'b1;
			minor_q <= minor_nxt;
			err_q   <= err_nxt;
		end
		if (emit) begin
			px_q   <= cmd_q.steep ? minor_q : major_q;
			py_q   <= cmd_q.steep ? major_q : minor_q;
			col_q  <= cmd_q.colour;
			last_q <= at_last;
		end
	end

	assign empty        = !out_valid_q;
	assign pixel_x      = FW'(px_q);
	assign pixel_y      = FW'(py_q);
	assign pixel_colour = col_q;
	assign last_pixel   = last_q;

endmodule

/* design/bresenham_line_rasterizer.sv */
// Top level of the Bresenham line rasterizer: front end, command FIFO, walker.
// Depends on bre_pkg, bre_front, bre_cmdq, bre_walk.
//
//   channel   handshake          payload
//   command   push / full        start_x start_y end_x end_y colour
//   pixel     pop / empty        pixel_x pixel_y pixel_colour last_pixel
//
// A command is loaded into the walker, which then gives one pixel per cycle
// while the output register is free or popped; the walker's error-term step
// is the pace setter. A two-entry command FIFO lets commands arrive while a
// line is walked. A stalled pixel holds the walker; reset empties the FIFO
// and the output register.
module bresenham_line_rasterizer #(
	parameter int COORD_BITS = bre_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [bre_pkg::FIELD_W-1:0]   start_x,
	input  logic [bre_pkg::FIELD_W-1:0]   start_y,
	input  logic [bre_pkg::FIELD_W-1:0]   end_x,
	input  logic [bre_pkg::FIELD_W-1:0]   end_y,
	input  logic [bre_pkg::COLOUR_W-1:0]  colour,
	output logic                          empty,
	input  logic                          pop,
	output logic [bre_pkg::FIELD_W-1:0]   pixel_x,
	output logic [bre_pkg::FIELD_W-1:0]   pixel_y,
	output logic [bre_pkg::COLOUR_W-1:0]  pixel_colour,
	output logic                          last_pixel
);

	localparam int ENTRY_W = bre_pkg::entry_width(COORD_BITS);

	logic [ENTRY_W-1:0] front_entry, q_entry;
	logic               q_empty, q_pop;

	// Classify the incoming command
	bre_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.start_x(start_x),
		.start_y(start_y),
		.end_x  (end_x),
		.end_y  (end_y),
		.colour (colour),
		.entry  (front_entry)
	);

	// Command FIFO between front end and walker
	bre_cmdq #(
		.WIDTH(ENTRY_W)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(front_entry),
		.full   (full),
		.rd_en  (q_pop),
		.rd_data(q_entry),
		.empty  (q_empty)
	);

	// Pixel walker
	bre_walk #(
		.COORD_BITS(COORD_BITS)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (q_entry),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_colour(pixel_colour),
		.last_pixel  (last_pixel)
	);

endmodule

/* design/bre_chk.sv */
// Port-level checks on the line rasterizer, bound to the top level.
// Depends on bre_pkg and bresenham_line_rasterizer.
module bre_chk #(
	parameter int COORD_BITS = bre_pkg::COORD_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         push,
	input logic                         full,
	input logic                         empty,
	input logic                         pop,
	input logic [bre_pkg::FIELD_W-1:0]  pixel_x,
	input logic [bre_pkg::FIELD_W-1:0]  pixel_y,
	input logic [bre_pkg::COLOUR_W-1:0] pixel_colour,
	input logic                         last_pixel
);

	localparam int FW = bre_pkg::FIELD_W;

	// A waiting pixel stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(pixel_colour) && $stable(last_pixel)))
		else $error("pixel changed while stalled");

	// Pixels stay inside the coordinate range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((pixel_x >> COORD_BITS) == '0 && (pixel_y >> COORD_BITS) == '0))
		else $error("pixel outside coordinate range");

	// Within a line the next pixel follows at once, same colour, next column or row
	a_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_pixel) |=> (!empty
			&& pixel_colour == $past(pixel_colour)
			&& (pixel_x == $past(pixel_x) || pixel_x == $past(pixel_x) + FW'(1)
				|| pixel_x == $past(pixel_x) - FW'(1))
			&& (pixel_y == $past(pixel_y) || pixel_y == $past(pixel_y) + FW'(1)
				|| pixel_y == $past(pixel_y) - FW'(1))
			&& (pixel_x != $past(pixel_x) || pixel_y != $past(pixel_y))))
		else $error("pixel not adjacent to previous pixel of the line");

	// A full command queue means a line is still being drawn
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !(empty && $past(empty) && $past(full, 2) && full && $past(full)
			&& $past(empty, 2)))
		else $error("commands stuck while no pixels are produced");

endmodule

bind bresenham_line_rasterizer bre_chk #(
	.COORD_BITS(COORD_BITS)
) u_bre_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.push        (push),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.pixel_colour(pixel_colour),
	.last_pixel  (last_pixel)
);

/* bench/bre_pixel_checker.sv */
// Pixel checker for the line rasterizer: watches the command and pixel queues,
// works out each line's pixels and compares them in order. Depends on bre_pkg.
`timescale 1ns / 100ps

module bre_pixel_checker #(
	parameter int COORD_BITS = bre_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic                         full,
	input  logic [bre_pkg::FIELD_W-1:0]  start_x,
	input  logic [bre_pkg::FIELD_W-1:0]  start_y,
	input  logic [bre_pkg::FIELD_W-1:0]  end_x,
	input  logic [bre_pkg::FIELD_W-1:0]  end_y,
	input  logic [bre_pkg::COLOUR_W-1:0] colour,
	input  logic                         empty,
	input  logic                         pop,
	input  logic [bre_pkg::FIELD_W-1:0]  pixel_x,
	input  logic [bre_pkg::FIELD_W-1:0]  pixel_y,
	input  logic [bre_pkg::COLOUR_W-1:0] pixel_colour,
	input  logic                         last_pixel,
	output int                           errors,
	output int                           pending,
	output int                           lines_seen,
	output int                           pixels_seen
);

	localparam int FIELD_W = bre_pkg::FIELD_W;
	localparam int COLOUR_W = bre_pkg::COLOUR_W;

	typedef struct packed {
		logic [FIELD_W-1:0]  x;
		logic [FIELD_W-1:0]  y;
		logic [COLOUR_W-1:0] colour;
		logic                last;
	} pixel_t;

	pixel_t pixel_q[$];

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t ns: pixel %0d: %s", $time, pixels_seen, msg);
	endtask

	// Walk one line the Bresenham way and queue its pixels in emission order
	function automatic void rasterize_line(
		input logic [FIELD_W-1:0] ax_in, input logic [FIELD_W-1:0] ay_in,
		input logic [FIELD_W-1:0] bx_in, input logic [FIELD_W-1:0] by_in,
		input logic [COLOUR_W-1:0] col
	);
		int mask, ax, ay, bx, by, t;
		int span_x, span_y, major_span, minor_span, err, minor_dir, major, minor;
		bit steep;
		pixel_t p;
		mask = (1 << COORD_BITS) - 1;
		ax = int'(ax_in) & mask;
		ay = int'(ay_in) & mask;
		bx = int'(bx_in) & mask;
		by = int'(by_in) & mask;
		span_x = (bx > ax) ? bx - ax : ax - bx;
		span_y = (by > ay) ? by - ay : ay - by;
		// diagonal lines stay column-major
		steep = span_y > span_x;
		if (steep) begin
			t = ax; ax = ay; ay = t;
			t = bx; bx = by; by = t;
		end
		// start from the endpoint with the smaller major coordinate
		if (ax > bx) begin
			t = ax; ax = bx; bx = t;
			t = ay; ay = by; by = t;
		end
		major_span = bx - ax;
		minor_span = (by > ay) ? by - ay : ay - by;
		err = major_span / 2;
		minor_dir = (ay < by) ? 1 : -1;
		minor = ay;
		for (major = ax; major <= bx; major++) begin
			p.x = FIELD_W'(steep ? minor : major);
			p.y = FIELD_W'(steep ? major : minor);
			p.colour = col;
			p.last = (major == bx);
			pixel_q.push_back(p);
			err -= minor_span;
			if (err < 0) begin
				minor += minor_dir;
				err += major_span;
			end
		end
	endfunction

	// Compare popped pixels first, then predict from an accepted command
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pixel_q.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel (%0d,%0d) colour %0d last %0b",
						pixel_x, pixel_y, pixel_colour, last_pixel));
				end else begin
					want = pixel_q.pop_front();
					if (pixel_x !== want.x)
						report_mismatch($sformatf("pixel_x got %0d, expected %0d",
							pixel_x, want.x));
					if (pixel_y !== want.y)
						report_mismatch($sformatf("pixel_y got %0d, expected %0d",
							pixel_y, want.y));
					if (pixel_colour !== want.colour)
						report_mismatch($sformatf("pixel_colour got %0d, expected %0d",
							pixel_colour, want.colour));
					if (last_pixel !== want.last)
						report_mismatch($sformatf("last_pixel got %0b, expected %0b",
							last_pixel, want.last));
				end
				pixels_seen++;
			end
			if (push && !full) begin
				rasterize_line(start_x, start_y, end_x, end_y, colour);
				lines_seen++;
			end
		end
		pending = pixel_q.size();
	end

endmodule

/* bench/tb_top.sv */
// Testbench top for the line rasterizer: drives line commands and pixel pops,
// gives the verdict. Depends on bre_pkg, bresenham_line_rasterizer, bre_pixel_checker.
`timescale 1ns / 100ps

module tb_top;

	localparam int FIELD_W = bre_pkg::FIELD_W;
	localparam int COLOUR_W = bre_pkg::COLOUR_W;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int HOLD_CYCLES = 400;
	// longest line plus its load, with margin
	localparam int DRAIN_CYCLES = (1 << bre_pkg::COORD_BITS_DEF) + 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty, last_pixel;
	logic [FIELD_W-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic [COLOUR_W-1:0] colour = '0;
	logic [FIELD_W-1:0] pixel_x, pixel_y;
	logic [COLOUR_W-1:0] pixel_colour;

	int errors, pending, lines_seen, pixels_seen;
	int cycles = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit rx_hold = 1'b0;
	int directed_lines = 0;

	always #6 clk = ~clk;

	bresenham_line_rasterizer dut (
		.clk, .arst_n, .push, .full,
		.start_x, .start_y, .end_x, .end_y, .colour,
		.empty, .pop, .pixel_x, .pixel_y, .pixel_colour, .last_pixel
	);

	bre_pixel_checker u_checker (
		.clk, .arst_n, .push, .full,
		.start_x, .start_y, .end_x, .end_y, .colour,
		.empty, .pop, .pixel_x, .pixel_y, .pixel_colour, .last_pixel,
		.errors, .pending, .lines_seen, .pixels_seen
	);

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d pixels outstanding", cycles, pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Pixel consumer: random stalls, or a full hold while rx_hold is up
	always @(negedge clk)
		pop <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);

	// One command transaction; called and returns at a falling edge
	task automatic send_line(input logic [FIELD_W-1:0] sx, input logic [FIELD_W-1:0] sy,
			input logic [FIELD_W-1:0] ex, input logic [FIELD_W-1:0] ey,
			input logic [COLOUR_W-1:0] col);
		while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		colour <= col;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	// Short lines most often, some axis-aligned, diagonal or single points, the rest anywhere
	task automatic send_random_line();
		int kind, len;
		logic [FIELD_W-1:0] sx, sy, ex, ey;
		kind = $urandom_range(0, 99);
		sx = FIELD_W'($urandom_range(0, 63));
		sy = FIELD_W'($urandom_range(0, 63));
		ex = FIELD_W'($urandom_range(0, 63));
		ey = FIELD_W'($urandom_range(0, 63));
		len = $urandom_range(0, 63);
		if (kind < 40) begin
			ex = FIELD_W'(int'(sx) + $urandom_range(0, 16) - 8);
			ey = FIELD_W'(int'(sy) + $urandom_range(0, 16) - 8);
		end else if (kind < 46) begin
			ey = sy;
		end else if (kind < 52) begin
			ex = sx;
		end else if (kind < 58) begin
			ex = FIELD_W'(int'(sx) + len);
			ey = FIELD_W'(int'(sy) + len);
			if (ex < sx || ey < sy) begin
				ex = sx;
				ey = sy;
			end
			if ($urandom_range(0, 1)) begin
				{sx, ex} = {ex, sx};
				{sy, ey} = {ey, sy};
			end
		end else if (kind < 62) begin
			ex = sx;
			ey = sy;
		end
		send_line(sx, sy, ex, ey, COLOUR_W'($urandom));
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct);
		tx_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		repeat (ITEMS_PER_PHASE) send_random_line();
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: single points, full-span axis lines, diagonals, steep and
		// reversed endpoints, colour extremes
		send_line(6'd0, 6'd0, 6'd0, 6'd0, 8'd0);
		send_line(6'd63, 6'd63, 6'd63, 6'd63, 8'd255);
		send_line(6'd0, 6'd0, 6'd63, 6'd0, 8'd1);
		send_line(6'd63, 6'd0, 6'd0, 6'd0, 8'd2);
		send_line(6'd0, 6'd0, 6'd0, 6'd63, 8'd4);
		send_line(6'd0, 6'd63, 6'd0, 6'd0, 8'd8);
		send_line(6'd0, 6'd0, 6'd63, 6'd63, 8'd16);
		send_line(6'd63, 6'd0, 6'd0, 6'd63, 8'd32);
		send_line(6'd0, 6'd63, 6'd63, 6'd0, 8'd64);
		send_line(6'd5, 6'd10, 6'd12, 6'd13, 8'd128);
		send_line(6'd12, 6'd13, 6'd5, 6'd10, 8'd127);
		send_line(6'd10, 6'd5, 6'd13, 6'd20, 8'd191);
		send_line(6'd13, 6'd20, 6'd10, 6'd5, 8'd223);
		send_line(6'd20, 6'd30, 6'd40, 6'd29, 8'd239);
		send_line(6'd40, 6'd29, 6'd20, 6'd30, 8'd247);
		send_line(6'd0, 6'd0, 6'd1, 6'd2, 8'd251);
		send_line(6'd63, 6'd62, 6'd62, 6'd63, 8'd253);
		send_line(6'd7, 6'd7, 6'd8, 6'd7, 8'd254);
		send_line(6'd42, 6'd21, 6'd21, 6'd42, 8'hAA);
		send_line(6'd21, 6'd42, 6'd42, 6'd21, 8'h55);
		send_line(6'd0, 6'd31, 6'd63, 6'd32, 8'h0F);
		send_line(6'd32, 6'd0, 6'd31, 6'd63, 8'hF0);
		directed_lines = 22;

		// Long consumer hold at the start of the free-running phase so the
		// command FIFO fills and full backs up the sender
		fork
			begin
				@(posedge clk);
				rx_hold = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
		join_none
		run_phase(0, 0);
		run_phase(53, 0);
		run_phase(0, 53);
		run_phase(19, 19);

		push <= 1'b0;
		rx_stall_pct = 0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d line commands (%0d directed) and %0d pixels under", lines_seen,
			directed_lines, pixels_seen);
		$display("free-running, sender-gap, consumer-stall and mixed traffic plus one long hold");
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
